// ===== src/sca_pkg.sv =====
package sca_pkg;

    localparam int FIFO_DEPTH = 256;
    localparam int ADDR_W     = $clog2(FIFO_DEPTH);

    typedef logic [ADDR_W-1:0] idx_t;
    typedef logic [6:0]        char_t;

    typedef struct packed {
        logic shift;
        logic ctrl;
        logic caps;
    } mods_t;

    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] SCROLL_NONE = 2'd0;
    localparam logic [1:0] SCROLL_UP   = 2'd1;
    localparam logic [1:0] SCROLL_DOWN = 2'd2;

    localparam logic [7:0] SC_PREFIX  = 8'hE0;
    localparam logic [6:0] SC_LSHIFT  = 7'h2A;
    localparam logic [6:0] SC_RSHIFT  = 7'h36;
    localparam logic [6:0] SC_CTRL    = 7'h1D;
    localparam logic [6:0] SC_CAPS    = 7'h3A;
    localparam logic [7:0] SC_PAGE_UP = 8'h49;
    localparam logic [7:0] SC_PAGE_DN = 8'h51;

    localparam char_t CH_LOWER_A = 7'h61;
    localparam char_t CH_LOWER_Z = 7'h7A;

    localparam char_t PLAIN_MAP [64] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam char_t SHIFT_MAP [64] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    function automatic idx_t sca_advance(input idx_t idx);
        idx_t res;
        if (idx == idx_t'(FIFO_DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + idx_t'(1);
        end
        return res;
    endfunction

endpackage

// ===== src/sca_keymap.sv =====
module sca_keymap
    import sca_pkg::*;
(
    input  logic [7:0] code,
    input  mods_t      mods,
    output char_t      ch,
    output logic       ch_valid
);

    char_t base;
    char_t shifted;
    logic  alpha;
    logic  upper;

    always_comb
    begin
        base     = (code[7:6] == 2'b00) ? PLAIN_MAP[code[5:0]] : '0;
        shifted  = SHIFT_MAP[code[5:0]];
        alpha    = (base >= CH_LOWER_A) && (base <= CH_LOWER_Z);
        upper    = alpha ? (mods.shift ^ mods.caps) : mods.shift;
        ch       = upper ? shifted : base;
        if (mods.ctrl && alpha)
        begin
            ch = {2'b00, ch[4:0]};
        end
        ch_valid = (base != '0);
    end

endmodule

// ===== src/scancode_to_ascii_with_fifo.sv =====
// Scancode set 1 to ASCII decoder with a character FIFO.
// The input channel (in_valid/in_ready) carries one item per transfer: with
// opcode 0 a raw scancode byte in scan_byte, with opcode 1 a request to pop
// one character. Every input transfer yields exactly one result transfer on
// the output channel (out_valid/out_ready) with char_out, has_data,
// scroll_event and dropped.
// Each item passes the memory read stage and then the output register
// before its result can transfer. Throughput is one item per cycle while
// the receiver takes results; the pace is set by the single-port character
// memory, which is written or read once per item with a registered read.
// The pipeline holds two items: when the receiver stalls, one more input is
// taken into the memory read stage, and in_ready then drops until the
// output register drains.
// Reset empties the FIFO and clears shift, ctrl, caps lock and the
// extended prefix. The FIFO holds FIFO_DEPTH-1 characters; a character
// decoded while it is full is discarded and reported through dropped.
module scancode_to_ascii_with_fifo
    import sca_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       opcode,
    input  logic [7:0] scan_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] char_out,
    output logic       has_data,
    output logic [1:0] scroll_event,
    output logic       dropped
);

    char_t mem [FIFO_DEPTH];
    char_t rdata_reg;

    idx_t  rd_idx_reg, rd_idx_next;
    idx_t  wr_idx_reg, wr_idx_next;
    mods_t mods_reg, mods_next;
    logic  prefix_reg, prefix_next;

    logic       a_valid_reg, a_valid_next;
    logic       a_read_reg;
    logic       a_has_reg;
    logic [1:0] a_scroll_reg;
    logic       a_drop_reg;

    logic       b_valid_reg, b_valid_next;
    char_t      b_char_reg;
    logic       b_has_reg;
    logic [1:0] b_scroll_reg;
    logic       b_drop_reg;

    logic       accept;
    logic       a_adv;
    logic       rd_en;
    logic       wr_en;
    logic       hit;
    logic [1:0] scroll;
    logic       drop;
    char_t      key_ch;
    logic       key_valid;

    sca_keymap u_keymap (
        .code     (scan_byte),
        .mods     (mods_reg),
        .ch       (key_ch),
        .ch_valid (key_valid)
    );

    assign a_adv    = a_valid_reg && (!b_valid_reg || out_ready);
    assign in_ready = !a_valid_reg || a_adv;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        mods_next   = mods_reg;
        prefix_next = prefix_reg;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        hit         = 1'b0;
        scroll      = SCROLL_NONE;
        drop        = 1'b0;
        if (accept)
        begin
            unique case (opcode)
                OP_READ:
                begin
                    if (rd_idx_reg != wr_idx_reg)
                    begin
                        rd_en       = 1'b1;
                        hit         = 1'b1;
                        rd_idx_next = sca_advance(rd_idx_reg);
                    end
                end
                OP_SCAN:
                begin
                    priority if (scan_byte == SC_PREFIX)
                    begin
                        prefix_next = 1'b1;
                    end
                    else if (prefix_reg)
                    begin
                        prefix_next = 1'b0;
                        if (!scan_byte[7] && scan_byte == SC_PAGE_UP)
                        begin
                            scroll = SCROLL_UP;
                        end
                        else if (!scan_byte[7] && scan_byte == SC_PAGE_DN)
                        begin
                            scroll = SCROLL_DOWN;
                        end
                    end
                    else if (scan_byte[7])
                    begin
                        if (scan_byte[6:0] == SC_LSHIFT || scan_byte[6:0] == SC_RSHIFT)
                        begin
                            mods_next.shift = 1'b0;
                        end
                        else if (scan_byte[6:0] == SC_CTRL)
                        begin
                            mods_next.ctrl = 1'b0;
                        end
                    end
                    else if (scan_byte[6:0] == SC_LSHIFT || scan_byte[6:0] == SC_RSHIFT)
                    begin
                        mods_next.shift = 1'b1;
                    end
                    else if (scan_byte[6:0] == SC_CTRL)
                    begin
                        mods_next.ctrl = 1'b1;
                    end
                    else if (scan_byte[6:0] == SC_CAPS)
                    begin
                        mods_next.caps = !mods_reg.caps;
                    end
                    else if (key_valid)
                    begin
                        if (sca_advance(wr_idx_reg) == rd_idx_reg)
                        begin
                            drop = 1'b1;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            wr_idx_next = sca_advance(wr_idx_reg);
                        end
                    end
                    else
                    begin
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_adv)
        begin
            a_valid_next = 1'b0;
        end
        b_valid_next = b_valid_reg;
        if (a_adv)
        begin
            b_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx_reg] <= key_ch;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg  <= '0;
            wr_idx_reg  <= '0;
            mods_reg    <= '0;
            prefix_reg  <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            rd_idx_reg  <= rd_idx_next;
            wr_idx_reg  <= wr_idx_next;
            mods_reg    <= mods_next;
            prefix_reg  <= prefix_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_read_reg   <= hit;
            a_has_reg    <= (rd_idx_next != wr_idx_next);
            a_scroll_reg <= scroll;
            a_drop_reg   <= drop;
        end
        if (a_adv)
        begin
            b_char_reg   <= a_read_reg ? rdata_reg : '0;
            b_has_reg    <= a_has_reg;
            b_scroll_reg <= a_scroll_reg;
            b_drop_reg   <= a_drop_reg;
        end
    end

    assign out_valid    = b_valid_reg;
    assign char_out     = b_char_reg;
    assign has_data     = b_has_reg;
    assign scroll_event = b_scroll_reg;
    assign dropped      = b_drop_reg;

endmodule

// ===== src/sca_checker.sv =====
module sca_checker
    import sca_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] char_out,
    input logic       has_data,
    input logic [1:0] scroll_event,
    input logic       dropped
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_out)
            && $stable(has_data) && $stable(scroll_event) && $stable(dropped))
    else $error("Stalled result changed before its transfer.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> scroll_event != 2'd3)
    else $error("Scroll event carries an undefined code.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_out != 7'd0 |-> scroll_event == SCROLL_NONE && !dropped)
    else $error("A read result reports a scroll event or a drop.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped |-> has_data)
    else $error("A character was dropped while the FIFO reports empty.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("Input is held off while the output register is empty.");

endmodule

bind scancode_to_ascii_with_fifo sca_checker u_sca_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .char_out     (char_out),
    .has_data     (has_data),
    .scroll_event (scroll_event),
    .dropped      (dropped)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import sca_pkg::*;

    localparam logic [7:0] SC_ALT     = 8'h38;
    localparam char_t      CH_UPPER_A = 7'h41;
    localparam char_t      CH_UPPER_Z = 7'h5A;

    localparam char_t KEY_PLAIN [64] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam char_t KEY_SHIFTED [64] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam logic [8:0] OPENING [25] = '{
        {OP_READ, 8'hFF},
        {OP_SCAN, 8'h1E},
        {OP_SCAN, 1'b0, SC_LSHIFT},
        {OP_SCAN, 8'h02},
        {OP_SCAN, 1'b1, SC_LSHIFT},
        {OP_SCAN, 1'b0, SC_CAPS},
        {OP_SCAN, 8'h10},
        {OP_SCAN, 1'b0, SC_RSHIFT},
        {OP_SCAN, 8'h10},
        {OP_SCAN, 1'b1, SC_RSHIFT},
        {OP_SCAN, 1'b0, SC_CAPS},
        {OP_SCAN, 1'b0, SC_CTRL},
        {OP_SCAN, 8'h2C},
        {OP_SCAN, 1'b1, SC_CTRL},
        {OP_SCAN, SC_PREFIX},
        {OP_SCAN, SC_PREFIX},
        {OP_SCAN, SC_PAGE_UP},
        {OP_SCAN, SC_PREFIX},
        {OP_SCAN, 1'b1, SC_PAGE_DN[6:0]},
        {OP_SCAN, SC_PREFIX},
        {OP_SCAN, SC_PAGE_DN},
        {OP_SCAN, SC_ALT},
        {OP_SCAN, 8'h7F},
        {OP_SCAN, 8'h80},
        {OP_READ, 8'h00}
    };

    typedef struct packed {
        char_t      chr;
        logic       has;
        logic [1:0] scroll;
        logic       drop;
    } key_result_t;

    class decode_board;
        char_t       char_ring [FIFO_DEPTH];
        idx_t        rd_ptr;
        idx_t        wr_ptr;
        logic        shift_on;
        logic        ctrl_on;
        logic        caps_on;
        logic        prefix_on;
        key_result_t pending_outputs [$];
        int          fails;

        function new();
            rd_ptr    = '0;
            wr_ptr    = '0;
            shift_on  = 1'b0;
            ctrl_on   = 1'b0;
            caps_on   = 1'b0;
            prefix_on = 1'b0;
            fails     = 0;
        endfunction

        function char_t key_char(input logic [6:0] code);
            char_t base;
            char_t c;
            logic  letter;
            logic  upper;
            if (code >= 7'd64)
            begin
                return '0;
            end
            base = KEY_PLAIN[code[5:0]];
            if (base == 7'h00)
            begin
                return '0;
            end
            letter = (base >= CH_LOWER_A) && (base <= CH_LOWER_Z);
            upper  = letter ? (shift_on ^ caps_on) : shift_on;
            c      = upper ? KEY_SHIFTED[code[5:0]] : base;
            if (ctrl_on)
            begin
                if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
                begin
                    c = c - CH_LOWER_A + 7'd1;
                end
                else if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
                begin
                    c = c - CH_UPPER_A + 7'd1;
                end
            end
            return c;
        endfunction

        function void predict_transfer(input logic op, input logic [7:0] b);
            key_result_t r;
            char_t       c;
            r = '0;
            if (op == OP_READ)
            begin
                if (rd_ptr != wr_ptr)
                begin
                    r.chr  = char_ring[rd_ptr];
                    rd_ptr = rd_ptr + idx_t'(1);
                end
            end
            else if (b == SC_PREFIX)
            begin
                prefix_on = 1'b1;
            end
            else if (prefix_on)
            begin
                prefix_on = 1'b0;
                if (b == SC_PAGE_UP)
                begin
                    r.scroll = SCROLL_UP;
                end
                else if (b == SC_PAGE_DN)
                begin
                    r.scroll = SCROLL_DOWN;
                end
            end
            else if (b[7])
            begin
                if (b[6:0] == SC_LSHIFT || b[6:0] == SC_RSHIFT)
                begin
                    shift_on = 1'b0;
                end
                else if (b[6:0] == SC_CTRL)
                begin
                    ctrl_on = 1'b0;
                end
            end
            else if (b[6:0] == SC_LSHIFT || b[6:0] == SC_RSHIFT)
            begin
                shift_on = 1'b1;
            end
            else if (b[6:0] == SC_CTRL)
            begin
                ctrl_on = 1'b1;
            end
            else if (b[6:0] == SC_CAPS)
            begin
                caps_on = ~caps_on;
            end
            else
            begin
                c = key_char(b[6:0]);
                if (c != 7'h00)
                begin
                    if (idx_t'(wr_ptr + idx_t'(1)) == rd_ptr)
                    begin
                        r.drop = 1'b1;
                    end
                    else
                    begin
                        char_ring[wr_ptr] = c;
                        wr_ptr            = wr_ptr + idx_t'(1);
                    end
                end
            end
            r.has = (rd_ptr != wr_ptr);
            pending_outputs.push_back(r);
        endfunction

        function void check_output(input char_t chr, input logic has,
                                   input logic [1:0] scroll, input logic drop);
            key_result_t want;
            if (pending_outputs.size() == 0)
            begin
                $error("Result transfer with no input transfer waiting for it.");
                fails++;
                return;
            end
            want = pending_outputs.pop_front();
            if (chr !== want.chr)
            begin
                $error("char_out: expected %0h, got %0h", want.chr, chr);
                fails++;
            end
            if (has !== want.has)
            begin
                $error("has_data: expected %0d, got %0d", want.has, has);
                fails++;
            end
            if (scroll !== want.scroll)
            begin
                $error("scroll_event: expected %0d, got %0d", want.scroll, scroll);
                fails++;
            end
            if (drop !== want.drop)
            begin
                $error("dropped: expected %0d, got %0d", want.drop, drop);
                fails++;
            end
        endfunction

        function int pending();
            return pending_outputs.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       opcode;
    logic [7:0] scan_byte;
    logic       out_valid;
    logic       out_ready;
    logic [6:0] char_out;
    logic       has_data;
    logic [1:0] scroll_event;
    logic       dropped;

    decode_board board;
    int          results_seen = 0;
    bit          steady = 1'b0;
    bit          long_hold_done = 1'b0;

    scancode_to_ascii_with_fifo DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .scan_byte    (scan_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .char_out     (char_out),
        .has_data     (has_data),
        .scroll_event (scroll_event),
        .dropped      (dropped)
    );

    always #10 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (steady || r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 2);
        end
        if (r < 97)
        begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [7:0] mapped_key();
        logic [5:0] c;
        do
        begin
            c = 6'($urandom_range(1, 63));
        end
        while (KEY_PLAIN[c] == 7'h00);
        return {2'b00, c};
    endfunction

    task automatic send_item(input logic op, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        opcode    <= op;
        scan_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (in_ready !== 1'b1);
        board.predict_transfer(op, b);
    endtask

    task automatic send_random();
        int r;
        r = $urandom_range(99);
        if (r < 30)
        begin
            send_item(OP_READ, 8'($urandom));
        end
        else if (r < 62)
        begin
            send_item(OP_SCAN, mapped_key());
        end
        else if (r < 74)
        begin
            case ($urandom_range(6))
                0: send_item(OP_SCAN, {1'b0, SC_LSHIFT});
                1: send_item(OP_SCAN, {1'b1, SC_LSHIFT});
                2: send_item(OP_SCAN, {1'b0, SC_RSHIFT});
                3: send_item(OP_SCAN, {1'b1, SC_RSHIFT});
                4: send_item(OP_SCAN, {1'b0, SC_CTRL});
                5: send_item(OP_SCAN, {1'b1, SC_CTRL});
                default: send_item(OP_SCAN, {1'b0, SC_CAPS});
            endcase
        end
        else if (r < 84)
        begin
            send_item(OP_SCAN, SC_PREFIX);
            case ($urandom_range(3))
                0: send_item(OP_SCAN, SC_PAGE_UP);
                1: send_item(OP_SCAN, SC_PAGE_DN);
                2: send_item(OP_SCAN, {1'b1, SC_PAGE_UP[6:0]});
                default: send_item(OP_SCAN, 8'($urandom));
            endcase
        end
        else
        begin
            send_item(OP_SCAN, 8'($urandom));
        end
    endtask

    task automatic drain_all();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            board.check_output(char_out, has_data, scroll_event, dropped);
            results_seen++;
        end
    end

    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!long_hold_done && results_seen >= 100)
            begin
                long_hold_done = 1'b1;
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (79) @(negedge clk);
            end
            stall = pick_gap();
            if (stall > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            repeat ($urandom_range(0, 5)) @(negedge clk);
        end
    end

    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        board     = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        opcode    = OP_SCAN;
        scan_byte = 8'h00;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (OPENING[i])
        begin
            send_item(OPENING[i][8], OPENING[i][7:0]);
        end

        // Fill the character queue past capacity so that presses get dropped.
        repeat (300)
        begin
            send_item(OP_SCAN, mapped_key());
        end
        drain_all();
        repeat (270)
        begin
            send_item(OP_READ, 8'($urandom));
        end

        steady = 1'b1;
        for (int n = 0; n < 780; n++)
        begin
            if (n == 150)
            begin
                steady = 1'b0;
            end
            send_random();
        end

        drain_all();
        repeat (10) @(posedge clk);
        if (board.fails == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/sca_pkg.sv
src/sca_keymap.sv
src/scancode_to_ascii_with_fifo.sv
src/sca_checker.sv
bench/tb.sv
